// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/edc_pkg.sv =====
// Shared types and constants for the elevator dispatch controller.
`default_nettype none

package edc_pkg;

    localparam int CAR_COUNT   = 2;
    localparam int CAR_SEL_W   = (CAR_COUNT > 1) ? $clog2(CAR_COUNT) : 1;
    localparam int CAR_IDX_W   = 4;
    localparam int FLOOR_W     = 8;
    localparam int STOP_CNT_W  = 2;
    localparam int TREE_LEAVES = 1 << CAR_SEL_W;
    localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;

    localparam logic [CAR_SEL_W-1:0]  CAR_LAST  = CAR_SEL_W'(CAR_COUNT - 1);
    localparam logic [STOP_CNT_W-1:0] STOP_FULL = 2'd2;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_REQUEST = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_ANSWER = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIR_STAY = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [FLOOR_W-1:0]   pickup_floor;
        logic [FLOOR_W-1:0]   target_floor;
    } cmd_t;

    typedef struct packed {
        kind_t                kind;
        logic [CAR_IDX_W-1:0] car_index;
        logic                 accepted;
        logic [FLOOR_W-1:0]   car_floor;
        dir_t                 direction;
        logic                 car_busy;
        logic                 last;
    } result_t;

    // One car after a tick.
    typedef struct packed {
        logic [FLOOR_W-1:0]    position;
        logic [STOP_CNT_W-1:0] count;
        logic [FLOOR_W-1:0]    head;
        dir_t                  direction;
    } car_step_t;

    // Outcome of the nearest idle car search.
    typedef struct packed {
        logic                 found;
        logic [CAR_SEL_W-1:0] idx;
    } pick_t;

endpackage

`default_nettype wire

// ===== src/edc_channels.sv =====
// Valid/ready channel interfaces for command and result words.
`default_nettype none

interface edc_cmd_if;
    import edc_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [FLOOR_W-1:0] pickup_floor;
    logic [FLOOR_W-1:0] target_floor;

    modport source (output valid, opcode, pickup_floor, target_floor, input ready);
    modport sink   (input valid, opcode, pickup_floor, target_floor, output ready);
endinterface

interface edc_res_if;
    import edc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [CAR_IDX_W-1:0] car_index;
    logic                 accepted;
    logic [FLOOR_W-1:0]   car_floor;
    logic [1:0]           direction;
    logic                 car_busy;
    logic                 last;

    modport source (output valid, kind, car_index, accepted, car_floor, direction,
                    car_busy, last, input ready);
    modport sink   (input valid, kind, car_index, accepted, car_floor, direction,
                    car_busy, last, output ready);
endinterface

`default_nettype wire

// ===== src/edc_car_step.sv =====
// One tick of one car: drop reached stops, then move toward the head stop.
`default_nettype none

module edc_car_step
    import edc_pkg::*;
(
    input  logic [FLOOR_W-1:0]    position,
    input  logic [STOP_CNT_W-1:0] count,
    input  logic [FLOOR_W-1:0]    head,
    input  logic [FLOOR_W-1:0]    tail,
    output car_step_t             step
);

    logic                  drop_head;
    logic [STOP_CNT_W-1:0] count_mid;
    logic [FLOOR_W-1:0]    head_mid;
    logic [STOP_CNT_W-1:0] count_new;

    always_comb
    begin
        drop_head = (count != '0) && (head == position);
        count_mid = drop_head ? count - 1'b1 : count;
        head_mid  = drop_head ? tail : head;
        // the promoted stop may be reached as well
        count_new = ((count_mid != '0) && (head_mid == position)) ? count_mid - 1'b1
                                                                  : count_mid;

        step.count     = count_new;
        step.head      = head_mid;
        step.position  = position;
        step.direction = DIR_STAY;
        if (count_new != '0)
        begin
            if (head_mid > position)
            begin
                step.position  = position + 1'b1;
                step.direction = DIR_UP;
            end
            else
            begin
                step.position  = position - 1'b1;
                step.direction = DIR_DOWN;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/edc_nearest.sv =====
// Nearest idle car search as a comparison tree; ties go to the higher index.
`default_nettype none

module edc_nearest
    import edc_pkg::*;
(
    input  logic [CAR_COUNT-1:0][FLOOR_W-1:0]    position,
    input  logic [CAR_COUNT-1:0][STOP_CNT_W-1:0] count,
    input  logic [FLOOR_W-1:0]                   pickup_floor,
    output pick_t                                pick
);

    logic [TREE_NODES-1:0]                node_ok;
    logic [TREE_NODES-1:0][FLOOR_W-1:0]   node_dist;
    logic [TREE_NODES-1:0][CAR_SEL_W-1:0] node_idx;

    always_comb
    begin
        node_ok   = '0;
        node_dist = '0;
        node_idx  = '0;
        for (int k = 0; k < TREE_LEAVES; k++)
        begin
            if (k < CAR_COUNT)
            begin
                node_ok[TREE_LEAVES-1+k]   = (count[k] == '0);
                node_dist[TREE_LEAVES-1+k] = (position[k] > pickup_floor)
                                             ? position[k] - pickup_floor
                                             : pickup_floor - position[k];
                node_idx[TREE_LEAVES-1+k]  = CAR_SEL_W'(k);
            end
        end
        // left child holds the lower car indexes
        for (int i = TREE_LEAVES - 2; i >= 0; i--)
        begin
            if (node_ok[2*i+2] &&
                (!node_ok[2*i+1] || node_dist[2*i+2] <= node_dist[2*i+1]))
            begin
                node_ok[i]   = 1'b1;
                node_dist[i] = node_dist[2*i+2];
                node_idx[i]  = node_idx[2*i+2];
            end
            else
            begin
                node_ok[i]   = node_ok[2*i+1];
                node_dist[i] = node_dist[2*i+1];
                node_idx[i]  = node_idx[2*i+1];
            end
        end
        pick.found = node_ok[0];
        pick.idx   = node_idx[0];
    end

endmodule

`default_nettype wire

// ===== src/elevator_dispatch_controller_core.sv =====
// Top level of the elevator dispatch controller.
//
//  channel | dir | words
//  --------+-----+------------------------------------------------
//  cmd     | in  | tick or ride request (opcode, pickup, target)
//  res     | out | request answer, or one report per car per tick
//
// A request's answer is loaded from the item register into the result register once it is free.
// A tick produces CAR_COUNT reports, one per cycle while the result side does not stall, stepped by the car counter.
// Throughput: one request per cycle while the result side does not stall; a tick holds the item until its last report.
// rst_n clears car floors to 1 and all stop counts at once; no clearing pass.
// A stalled result holds in the result register; the item register takes the
// next word as soon as the current item's final result is loaded.
`default_nettype none

module elevator_dispatch_controller_core
    import edc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    edc_cmd_if.sink   cmd,
    edc_res_if.source res
);

    logic                                  item_valid_reg;
    cmd_t                                  item_reg;
    logic [CAR_SEL_W-1:0]                  car_cnt_reg;
    logic [CAR_COUNT-1:0][FLOOR_W-1:0]    position_reg;
    logic [CAR_COUNT-1:0][STOP_CNT_W-1:0] count_reg;
    logic [FLOOR_W-1:0]                    head_reg [CAR_COUNT];
    logic [FLOOR_W-1:0]                    tail_reg [CAR_COUNT];
    logic                                  res_valid_reg;
    result_t                               res_reg;
    result_t                               res_next;

    logic      out_free;
    logic      fire;
    logic      is_tick;
    logic      item_last;
    logic      cmd_take;
    car_step_t step;
    pick_t     pick;

    assign out_free  = !res_valid_reg || res.ready;
    assign fire      = item_valid_reg && out_free;
    assign is_tick   = (item_reg.opcode == OP_TICK);
    assign item_last = !is_tick || (car_cnt_reg == CAR_LAST);
    assign cmd.ready = !item_valid_reg || (fire && item_last);
    assign cmd_take  = cmd.valid && cmd.ready;

    edc_car_step u_step (
        .position (position_reg[car_cnt_reg]),
        .count    (count_reg[car_cnt_reg]),
        .head     (head_reg[car_cnt_reg]),
        .tail     (tail_reg[car_cnt_reg]),
        .step     (step)
    );

    edc_nearest u_nearest (
        .position     (position_reg),
        .count        (count_reg),
        .pickup_floor (item_reg.pickup_floor),
        .pick         (pick)
    );

    always_comb
    begin
        res_next = '0;
        if (is_tick)
        begin
            res_next.kind      = KIND_REPORT;
            res_next.car_index = CAR_IDX_W'(car_cnt_reg);
            res_next.car_floor = step.position;
            res_next.direction = step.direction;
            res_next.car_busy  = (step.count != '0);
            res_next.last      = (car_cnt_reg == CAR_LAST);
        end
        else
        begin
            res_next.kind = KIND_ANSWER;
            res_next.last = 1'b1;
            if (pick.found)
            begin
                res_next.car_index = CAR_IDX_W'(pick.idx);
                res_next.accepted  = 1'b1;
                res_next.car_floor = position_reg[pick.idx];
                res_next.car_busy  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            car_cnt_reg    <= '0;
            res_valid_reg  <= 1'b0;
            for (int c = 0; c < CAR_COUNT; c++)
            begin
                position_reg[c] <= FLOOR_W'(1);
                count_reg[c]    <= '0;
            end
        end
        else
        begin
            if (cmd_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (fire && item_last)
            begin
                item_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (fire && is_tick)
            begin
                car_cnt_reg                <= item_last ? '0 : car_cnt_reg + 1'b1;
                position_reg[car_cnt_reg] <= step.position;
                count_reg[car_cnt_reg]    <= step.count;
            end
            else if (fire && pick.found)
            begin
                count_reg[pick.idx] <= STOP_FULL;
            end
        end
    end

    // payload: item, stop slots and result word
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            item_reg.opcode       <= opcode_t'(cmd.opcode);
            item_reg.pickup_floor <= cmd.pickup_floor;
            item_reg.target_floor <= cmd.target_floor;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
        if (fire && is_tick)
        begin
            head_reg[car_cnt_reg] <= step.head;
        end
        else if (fire && pick.found)
        begin
            head_reg[pick.idx] <= item_reg.pickup_floor;
            tail_reg[pick.idx] <= item_reg.target_floor;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.kind      = res_reg.kind;
    assign res.car_index = res_reg.car_index;
    assign res.accepted  = res_reg.accepted;
    assign res.car_floor = res_reg.car_floor;
    assign res.direction = res_reg.direction;
    assign res.car_busy  = res_reg.car_busy;
    assign res.last      = res_reg.last;

endmodule

`default_nettype wire

// ===== src/edc_checker.sv =====
// Port-level checker for the dispatch controller, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module edc_checker
    import edc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic                 res_kind,
    input logic [CAR_IDX_W-1:0] res_car_index,
    input logic                 res_accepted,
    input logic [FLOOR_W-1:0]   res_car_floor,
    input logic [1:0]           res_direction,
    input logic                 res_car_busy,
    input logic                 res_last
);

    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_car_floor) && $stable(res_last), "result word dropped or changed while stalled")
    `ASSERT_SAME(a_answer_last, clk, rst_n, res_valid && res_kind == KIND_ANSWER, res_last && res_direction == DIR_STAY, "request answer must be single and stationary")
    `ASSERT_SAME(a_reject_zero, clk, rst_n, res_valid && res_kind == KIND_ANSWER && !res_accepted, res_car_index == '0 && res_car_floor == '0 && !res_car_busy, "rejected answer carries car data")
    `ASSERT_SAME(a_move_busy, clk, rst_n, res_valid && res_kind == KIND_REPORT && res_direction != DIR_STAY, res_car_busy && !res_accepted, "moving car reported idle")

endmodule

bind elevator_dispatch_controller_core edc_checker u_edc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_kind      (res.kind),
    .res_car_index (res.car_index),
    .res_accepted  (res.accepted),
    .res_car_floor (res.car_floor),
    .res_direction (res.direction),
    .res_car_busy  (res.car_busy),
    .res_last      (res.last)
);

`default_nettype wire
